[sv/s256h_pkg.sv]
// shared types, constants and round functions of the sha-256 stream hasher
`timescale 1ns / 1ps

package s256h_pkg;

    localparam int unsigned BLOCK_BITS = 512;
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned NUM_WORDS  = 8;
    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned CNT_BITS   = 61;   // width of the message byte count, bits = count * 8

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] FILL_LAST     = 6'd63;
    localparam logic [2:0] LEN_ZONE      = 3'd7;  // fill positions 56..63 hold the length
    localparam logic [5:0] ROUND_LAST    = 6'd63;

    localparam logic [31:0] H_INIT [NUM_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD
    } t_state;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } t_pad;

    typedef struct packed {
        logic       take_byte;   // shift the input byte in and count it
        logic       pad;         // shift a padding byte in
        t_pad       pad_kind;
        logic       load;        // working vars <= hash words
        logic       round;       // one compression round
        logic [5:0] round_idx;
        logic       fold;        // hash words += working vars
        logic       fold_final;  // digest to output, hash back to initial
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       out_busy;
    } t_stat;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (WORD_BITS - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[sv/s256h_ctrl.sv]
// controller state machine of the sha-256 stream hasher
`timescale 1ns / 1ps

module s256h_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_byte_valid,
    input  logic              i_last_byte,
    output logic              o_in_ready,
    input  s256h_pkg::t_stat  i_stat,
    output s256h_pkg::t_cmd   o_cmd
);
    import s256h_pkg::*;

    t_state     r_state, n_state;
    logic [5:0] r_round, n_round;
    logic       r_last, n_last;      // message end seen, padding still to do
    logic       r_first, n_first;    // next pad byte is the 0x80 mark
    logic       r_len_ok, n_len_ok;  // this block is the one that takes the length
    logic       r_final, n_final;    // block under compression is the last one
    logic       len_ok_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_round  <= '0;
            r_last   <= 1'b0;
            r_first  <= 1'b0;
            r_len_ok <= 1'b0;
            r_final  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_round  <= n_round;
            r_last   <= n_last;
            r_first  <= n_first;
            r_len_ok <= n_len_ok;
            r_final  <= n_final;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_round  = r_round;
        n_last   = r_last;
        n_first  = r_first;
        n_len_ok = r_len_ok;
        n_final  = r_final;
        len_ok_nx = r_len_ok;

        o_in_ready          = 1'b0;
        o_cmd.take_byte     = 1'b0;
        o_cmd.pad           = 1'b0;
        o_cmd.pad_kind      = PAD_ZERO;
        o_cmd.load          = 1'b0;
        o_cmd.round         = 1'b0;
        o_cmd.round_idx     = r_round;
        o_cmd.fold          = 1'b0;
        o_cmd.fold_final    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_byte = i_byte_valid;
                    if (i_byte_valid && (i_stat.fill == FILL_LAST)) begin
                        n_state  = ST_LOAD;
                        n_last   = i_last_byte;
                        n_first  = i_last_byte;
                        n_len_ok = 1'b0;
                        n_final  = 1'b0;
                    end else if (i_last_byte) begin
                        n_state  = ST_PAD;
                        n_last   = 1'b1;
                        n_first  = 1'b1;
                        n_len_ok = 1'b0;
                    end
                end
            end
            ST_PAD: begin
                o_cmd.pad = 1'b1;
                if (r_first) begin
                    o_cmd.pad_kind = PAD_MARK;
                    // mark below position 56 leaves room for the length here
                    len_ok_nx = (i_stat.fill[5:3] != LEN_ZONE);
                end else if (r_len_ok && (i_stat.fill[5:3] == LEN_ZONE)) begin
                    o_cmd.pad_kind = PAD_LEN;
                end else begin
                    o_cmd.pad_kind = PAD_ZERO;
                end
                n_first  = 1'b0;
                n_len_ok = len_ok_nx;
                if (i_stat.fill == FILL_LAST) begin
                    n_state = ST_LOAD;
                    n_final = len_ok_nx;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_round    = '0;
                n_state    = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_round     = r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_final) begin
                    // digest waits here until the previous one has drained
                    if (!i_stat.out_busy) begin
                        o_cmd.fold_final = 1'b1;
                        n_last  = 1'b0;
                        n_final = 1'b0;
                        n_state = ST_IDLE;
                    end
                end else begin
                    o_cmd.fold = 1'b1;
                    if (r_last) begin
                        n_state = ST_PAD;
                        if (!r_first) begin
                            n_len_ok = 1'b1;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/s256h_dp.sv]
// datapath of the sha-256 stream hasher: block and schedule line, rounds, hash, digest output
`timescale 1ns / 1ps

module s256h_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  s256h_pkg::t_cmd   i_cmd,
    input  logic [7:0]        i_data_byte,
    output s256h_pkg::t_stat  o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [31:0]       o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_last_word
);
    import s256h_pkg::*;

    // word 0 of the block sits in the top bits; bytes shift in at the bottom
    logic [BLOCK_BITS-1:0] r_blk;
    logic [31:0]           r_v [NUM_WORDS];
    logic [31:0]           r_h [NUM_WORDS];
    logic [31:0]           r_out_words [NUM_WORDS];
    logic [5:0]            r_fill;
    logic [CNT_BITS-1:0]   r_nbytes;
    logic [3:0]            r_out_left;
    logic [2:0]            r_out_idx;

    logic [31:0] w0, w1, w9, w14, sched_new, t1, t2;
    logic [63:0] len_bits;
    logic [7:0]  len_byte, pad_byte, shift_byte;
    logic        shift_en, out_take;

    assign w0  = r_blk[511:480];
    assign w1  = r_blk[479:448];
    assign w9  = r_blk[223:192];
    assign w14 = r_blk[63:32];
    assign sched_new = ssig1(w14) + w9 + ssig0(w1) + w0;

    assign t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + K_TAB[i_cmd.round_idx] + w0;
    assign t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign len_bits = {r_nbytes, 3'b000};

    always_comb begin
        unique case (r_fill[2:0])
            3'd0:    len_byte = len_bits[63:56];
            3'd1:    len_byte = len_bits[55:48];
            3'd2:    len_byte = len_bits[47:40];
            3'd3:    len_byte = len_bits[39:32];
            3'd4:    len_byte = len_bits[31:24];
            3'd5:    len_byte = len_bits[23:16];
            3'd6:    len_byte = len_bits[15:8];
            default: len_byte = len_bits[7:0];
        endcase
    end

    always_comb begin
        unique case (i_cmd.pad_kind)
            PAD_MARK: pad_byte = PAD_MARK_BYTE;
            PAD_LEN:  pad_byte = len_byte;
            default:  pad_byte = 8'h00;
        endcase
    end

    assign shift_en   = i_cmd.take_byte | i_cmd.pad;
    assign shift_byte = i_cmd.pad ? pad_byte : i_data_byte;
    assign out_take   = o_out_valid & i_out_ready;

    // payload
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            r_blk <= {r_blk[BLOCK_BITS-9:0], shift_byte};
        end else if (i_cmd.round) begin
            r_blk <= {r_blk[BLOCK_BITS-33:0], sched_new};
        end

        if (i_cmd.load) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_v[k] <= r_h[k];
            end
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end

        if (i_cmd.fold_final) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_out_words[k] <= r_h[k] + r_v[k];
            end
        end else if (out_take) begin
            for (int k = 0; k < NUM_WORDS - 1; k++) begin
                r_out_words[k] <= r_out_words[k+1];
            end
        end
    end

    // control and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_nbytes   <= '0;
            r_out_left <= '0;
            r_out_idx  <= '0;
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_h[k] <= H_INIT[k];
            end
        end else begin
            if (shift_en) begin
                r_fill <= r_fill + 6'd1;
            end

            if (i_cmd.fold_final) begin
                r_nbytes <= '0;
            end else if (i_cmd.take_byte) begin
                r_nbytes <= r_nbytes + CNT_BITS'(1);
            end

            if (i_cmd.fold_final) begin
                for (int k = 0; k < NUM_WORDS; k++) begin
                    r_h[k] <= H_INIT[k];
                end
            end else if (i_cmd.fold) begin
                for (int k = 0; k < NUM_WORDS; k++) begin
                    r_h[k] <= r_h[k] + r_v[k];
                end
            end

            if (i_cmd.fold_final) begin
                r_out_left <= 4'(NUM_WORDS);
                r_out_idx  <= '0;
            end else if (out_take) begin
                r_out_left <= r_out_left - 4'd1;
                r_out_idx  <= r_out_idx + 3'd1;
            end
        end
    end

    assign o_out_valid     = (r_out_left != 4'd0);
    assign o_digest_word   = r_out_words[0];
    assign o_word_index    = r_out_idx;
    assign o_last_word     = (r_out_idx == 3'd7);
    assign o_stat.fill     = r_fill;
    assign o_stat.out_busy = o_out_valid;

endmodule

[sv/sha256_stream_hasher_core.sv]
// top level of the sha-256 stream hasher
//
//  channel   dir  payload                                  item
//  s_axis    in   tdata[7:0] byte, tuser valid, tlast end  one message byte or end mark
//  m_axis    out  tdata[31:0] word, tuser index, tlast     one digest word, 8 per message
//
// a byte item is taken while s_axis_tready is high; the 64th byte of a block starts a
// compression (load, 64 rounds on one shared round unit, fold) with s_axis_tready low
// an end mark feeds the padding one byte a cycle, outside compressions, through the
// same byte path (64 minus fill, plus 64 more when the tail is 56 bytes or longer)
// with one or two compressions
// the digest sits in its own output register and drains while the next message
// streams in; a second digest waits at its final fold until the first is gone
// i_rst_n is synchronous; block and schedule storage need no clearing
`timescale 1ns / 1ps

module sha256_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);
    import s256h_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing: byte intake, padding, round count
    s256h_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_byte_valid (s_axis_tuser),
        .i_last_byte  (s_axis_tlast),
        .o_in_ready   (s_axis_tready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    // block line doubling as schedule, round unit, hash words, digest register
    s256h_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (s_axis_tdata),
        .o_stat        (stat),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_digest_word (m_axis_tdata),
        .o_word_index  (m_axis_tuser),
        .o_last_word   (m_axis_tlast)
    );

endmodule
